### rtl/core/playfair_pair_decrypt_top_macros.svh
// Assertion macros for the Playfair pair decrypt block.
// Used by playfair_pair_decrypt_top; expects clk and rst_n in scope.
`ifndef PLAYFAIR_PAIR_DECRYPT_TOP_MACROS_SVH
`define PLAYFAIR_PAIR_DECRYPT_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define PFD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfd assertion failed");
`define PFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfd assertion failed");
`else
`define PFD_ASSERT_SAME(label, ante, cons)
`define PFD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/core/pfd_pkg.sv
// Package for the Playfair pair decrypt block: types, codes, reset values.
// No dependencies.
package pfd_pkg;

  localparam int SIDE = 5;
  localparam int LETTER_W = 5;
  localparam int POS_W = 3;
  localparam int CFG_W = 45;
  localparam int CFG_IDX_W = 2;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [POS_W-1:0] pos_t;

  // grid[row][col]; packed so cell k = row*5+col sits at bits 5k..5k+4
  typedef logic [SIDE-1:0][SIDE-1:0][LETTER_W-1:0] cell_grid_t;

  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;
  localparam pos_t POS_LAST = 3'd4;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_SAME = 2'd1;
  localparam logic [1:0] STATUS_MISSING = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_0_TO_8 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_9_TO_17 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_18_TO_24 = 2'd2;

  localparam logic [44:0] SQ0_RST = 45'd9043225708576;
  localparam logic [44:0] SQ1_RST = 45'd20393023156586;
  localparam logic [34:0] SQ2_RST = 35'd27673712275;

  typedef struct packed {
    letter_t cipher_first;
    letter_t cipher_second;
  } in_item_t;

  typedef struct packed {
    letter_t plain_first;
    letter_t plain_second;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic found;
    pos_t row;
    pos_t col;
  } cell_loc_t;

  function automatic pos_t prev_pos(input pos_t p);
    prev_pos = (p == '0) ? POS_LAST : p - 3'd1;
  endfunction

endpackage

### rtl/core/pfd_locate.sv
// Finds a letter in the key square by parallel compare, lowest cell wins.
// Depends on pfd_pkg.
module pfd_locate import pfd_pkg::*; (
  input  cell_grid_t grid,
  input  letter_t    letter,
  output cell_loc_t  loc
);

  always_comb begin
    loc = '0;
    for (int r = SIDE - 1; r >= 0; r--) begin
      for (int c = SIDE - 1; c >= 0; c--) begin
        if (grid[r][c] == letter) begin
          loc.found = 1'b1;
          loc.row = POS_W'(r);
          loc.col = POS_W'(c);
        end
      end
    end
  end

endmodule

### rtl/core/pfd_select.sv
// Picks the two plaintext cells from the located positions (row, column, rectangle).
// Depends on pfd_pkg.
module pfd_select import pfd_pkg::*; (
  input  cell_grid_t grid,
  input  cell_loc_t  loc_a,
  input  cell_loc_t  loc_b,
  output letter_t    plain_a,
  output letter_t    plain_b
);

  always_comb begin
    if (loc_a.row == loc_b.row) begin
      plain_a = grid[loc_a.row][prev_pos(loc_a.col)];
      plain_b = grid[loc_b.row][prev_pos(loc_b.col)];
    end else if (loc_a.col == loc_b.col) begin
      plain_a = grid[prev_pos(loc_a.row)][loc_a.col];
      plain_b = grid[prev_pos(loc_b.row)][loc_b.col];
    end else begin
      plain_a = grid[loc_a.row][loc_b.col];
      plain_b = grid[loc_b.row][loc_a.col];
    end
  end

endmodule

### rtl/core/playfair_pair_decrypt_top.sv
// Top level of the Playfair pair decrypt block: config registers, pipeline.
// Depends on pfd_pkg, pfd_locate, pfd_select, playfair_pair_decrypt_top_macros.svh.
//
//   channel | ports                        | handshake
//   input   | start, busy, in_data         | accepted when start && !busy
//   result  | out_valid, out_data          | one-cycle strobe, no back-pressure
//   config  | cfg_we, cfg_idx, cfg_wdata   | written when cfg_we is high
//
// One transaction per cycle; an accepted pair passes the input register, then
// compare/select into the result register, which drives the result strobe.
// busy is always low. Synchronous active-low reset clears valid flags and
// loads the default square. The receiver cannot stall, so nothing backs up.
`include "playfair_pair_decrypt_top_macros.svh"

module playfair_pair_decrypt_top import pfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [44:0] sq0_r, sq0_nxt;
  logic [44:0] sq1_r, sq1_nxt;
  logic [34:0] sq2_r, sq2_nxt;
  cell_grid_t  grid;

  logic     in_fire;
  logic     stg_valid_r;
  letter_t  stg_a_r, stg_b_r;
  letter_t  map_a, map_b;

  cell_loc_t loc_a, loc_b;
  letter_t   plain_a, plain_b;
  out_item_t out_nxt;
  out_item_t out_data_r;
  logic      out_valid_r;

  assign busy = 1'b0;
  assign in_fire = start && !busy;

  always_comb begin
    sq0_nxt = sq0_r;
    sq1_nxt = sq1_r;
    sq2_nxt = sq2_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_CELLS_0_TO_8:   sq0_nxt = cfg_wdata;
        CFG_CELLS_9_TO_17:  sq1_nxt = cfg_wdata;
        CFG_CELLS_18_TO_24: sq2_nxt = cfg_wdata[34:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq0_r <= SQ0_RST;
      sq1_r <= SQ1_RST;
      sq2_r <= SQ2_RST;
    end else begin
      sq0_r <= sq0_nxt;
      sq1_r <= sq1_nxt;
      sq2_r <= sq2_nxt;
    end
  end

  assign grid = {sq2_r, sq1_r, sq0_r};

  // J folds onto I
  assign map_a = (in_data.cipher_first == LETTER_J) ? LETTER_I : in_data.cipher_first;
  assign map_b = (in_data.cipher_second == LETTER_J) ? LETTER_I : in_data.cipher_second;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_a_r <= map_a;
      stg_b_r <= map_b;
    end
  end

  pfd_locate u_locate_a (
    .grid   (grid),
    .letter (stg_a_r),
    .loc    (loc_a)
  );

  pfd_locate u_locate_b (
    .grid   (grid),
    .letter (stg_b_r),
    .loc    (loc_b)
  );

  pfd_select u_select (
    .grid    (grid),
    .loc_a   (loc_a),
    .loc_b   (loc_b),
    .plain_a (plain_a),
    .plain_b (plain_b)
  );

  always_comb begin
    out_nxt = '0;
    if (stg_a_r == stg_b_r) begin
      out_nxt.status = STATUS_SAME;
    end else if (!loc_a.found || !loc_b.found) begin
      out_nxt.status = STATUS_MISSING;
    end else begin
      out_nxt.plain_first = plain_a;
      out_nxt.plain_second = plain_b;
      out_nxt.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stg_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_valid_r) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  `PFD_ASSERT_NEXT(a_accept_reaches_stage, in_fire, stg_valid_r)
  `PFD_ASSERT_SAME(a_result_has_source, out_valid, $past(in_fire, 2))
  `PFD_ASSERT_SAME(a_error_zero_letters, out_valid && (out_data.status != STATUS_OK),
                   (out_data.plain_first == '0) && (out_data.plain_second == '0))

endmodule

### tb/tb_playfair_pair_decrypt_top.sv
// Self-checking testbench for playfair_pair_decrypt_top: drives digraphs and key squares,
// predicts each decrypted pair and compares it with the result strobe.
// Depends on pfd_pkg and the playfair_pair_decrypt_top RTL.
module tb_playfair_pair_decrypt_top import pfd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {SQ_KEY, SQ_CODES, SQ_REPEATS, SQ_RAW, SQ_DEFAULT, SQ_ZERO, SQ_ONES}
    square_kind_t;

  localparam logic [124:0] DEFAULT_SQUARE = {SQ2_RST, SQ1_RST, SQ0_RST};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             in_data = '0;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_CELLS_0_TO_8;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  in_item_t    pending_digraphs[$];
  out_item_t   expected_plain[$];
  logic [124:0] key_shadow = DEFAULT_SQUARE;
  letter_t     gen_cells[25];
  int          send_gap_pct = 34;
  int          err_count = 0;
  int          ok_seen = 0;
  int          same_seen = 0;
  int          missing_seen = 0;
  int          squares_loaded = 0;

  playfair_pair_decrypt_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic out_item_t decipher_pair(input in_item_t d, input logic [124:0] sq);
    letter_t   a, b;
    int        ka, kb, r1, c1, r2, c2, p1, p2;
    out_item_t res;
    a = (d.cipher_first == LETTER_J) ? LETTER_I : d.cipher_first;
    b = (d.cipher_second == LETTER_J) ? LETTER_I : d.cipher_second;
    res = '0;
    res.status = STATUS_OK;
    if (a == b) begin
      res.status = STATUS_SAME;
      return res;
    end
    ka = SIDE * SIDE;
    kb = SIDE * SIDE;
    for (int k = SIDE * SIDE - 1; k >= 0; k--) begin
      if (sq[5*k +: 5] == a) ka = k;
      if (sq[5*k +: 5] == b) kb = k;
    end
    if (ka == SIDE * SIDE || kb == SIDE * SIDE) begin
      res.status = STATUS_MISSING;
      return res;
    end
    r1 = ka / SIDE;
    c1 = ka % SIDE;
    r2 = kb / SIDE;
    c2 = kb % SIDE;
    if (r1 == r2) begin
      p1 = r1 * SIDE + (c1 + SIDE - 1) % SIDE;
      p2 = r2 * SIDE + (c2 + SIDE - 1) % SIDE;
    end else if (c1 == c2) begin
      p1 = ((r1 + SIDE - 1) % SIDE) * SIDE + c1;
      p2 = ((r2 + SIDE - 1) % SIDE) * SIDE + c2;
    end else begin
      p1 = r1 * SIDE + c2;
      p2 = r2 * SIDE + c1;
    end
    res.plain_first = sq[5*p1 +: 5];
    res.plain_second = sq[5*p2 +: 5];
    return res;
  endfunction

  // mostly letters from the loaded square, biased toward shared rows and columns
  function automatic in_item_t make_digraph();
    in_item_t d;
    int       sel, ia, ib;
    sel = $urandom_range(99);
    ia = $urandom_range(24);
    ib = $urandom_range(24);
    if (sel < 20) ib = (ia / SIDE) * SIDE + $urandom_range(SIDE - 1);
    else if (sel < 40) ib = $urandom_range(SIDE - 1) * SIDE + ia % SIDE;
    d.cipher_first = gen_cells[ia];
    d.cipher_second = gen_cells[ib];
    if (sel >= 40 && sel < 48) d.cipher_second = d.cipher_first;
    else if (sel >= 48 && sel < 58) d.cipher_first = letter_t'($urandom_range(31));
    else if (sel >= 58 && sel < 66) d.cipher_second = letter_t'($urandom_range(31));
    if (d.cipher_first == LETTER_I && $urandom_range(1)) d.cipher_first = LETTER_J;
    if (d.cipher_second == LETTER_I && $urandom_range(1)) d.cipher_second = LETTER_J;
    return d;
  endfunction

  task automatic send_pair(input int first, input int second);
    in_item_t d;
    d.cipher_first = letter_t'(first);
    d.cipher_second = letter_t'(second);
    pending_digraphs = {pending_digraphs, d};
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_digraphs.size() != 0 || start || expected_plain.size() != 0);
  endtask

  task automatic load_square(input square_kind_t kind);
    letter_t      pool[$];
    letter_t      t;
    logic [124:0] flat;
    int           j;
    pool = {};
    flat = '0;
    case (kind)
      SQ_KEY, SQ_REPEATS: begin
        for (int c = 0; c < 26; c++) if (c != LETTER_J) pool = {pool, letter_t'(c)};
      end
      SQ_CODES: begin
        for (int c = 0; c < 32; c++) pool = {pool, letter_t'(c)};
      end
      SQ_RAW: flat = 125'({$urandom, $urandom, $urandom, $urandom});
      SQ_DEFAULT: flat = DEFAULT_SQUARE;
      SQ_ZERO: flat = '0;
      SQ_ONES: flat = '1;
      default: flat = DEFAULT_SQUARE;
    endcase
    if (pool.size() != 0) begin
      for (int i = pool.size() - 1; i > 0; i--) begin
        j = $urandom_range(i);
        t = pool[i];
        pool[i] = pool[j];
        pool[j] = t;
      end
      for (int k = 0; k < 25; k++) flat[5*k +: 5] = pool[k];
      if (kind == SQ_REPEATS) begin
        repeat ($urandom_range(4, 2)) flat[5*$urandom_range(24) +: 5] =
          flat[5*$urandom_range(24) +: 5];
      end
    end
    for (int k = 0; k < 25; k++) gen_cells[k] = flat[5*k +: 5];
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_CELLS_0_TO_8;
    cfg_wdata <= flat[44:0];
    @(posedge clk);
    cfg_idx <= CFG_CELLS_9_TO_17;
    cfg_wdata <= flat[89:45];
    @(posedge clk);
    cfg_idx <= CFG_CELLS_18_TO_24;
    cfg_wdata <= {10'($urandom), flat[124:90]};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    squares_loaded++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
    end else if (!start || !busy) begin
      if (pending_digraphs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        start <= 1'b1;
        in_data <= pending_digraphs.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // shadow of the key square registers and the prediction of each accepted pair
  always @(posedge clk) begin
    if (!rst_n) begin
      key_shadow = DEFAULT_SQUARE;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_CELLS_0_TO_8: key_shadow[44:0] = cfg_wdata;
          CFG_CELLS_9_TO_17: key_shadow[89:45] = cfg_wdata;
          CFG_CELLS_18_TO_24: key_shadow[124:90] = cfg_wdata[34:0];
          default: ;
        endcase
      end
      if (start && !busy) expected_plain = {expected_plain, decipher_pair(in_data, key_shadow)};
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_plain.size() == 0) begin
        err_count++;
        $display("%0t unexpected transaction: got %0d/%0d status %0d", $time,
                 out_data.plain_first, out_data.plain_second, out_data.status);
      end else begin
        want = expected_plain.pop_front();
        if (out_data.plain_first !== want.plain_first ||
            out_data.plain_second !== want.plain_second ||
            out_data.status !== want.status) begin
          err_count++;
          $display("%0t mismatch: expected %0d/%0d status %0d, got %0d/%0d status %0d",
                   $time, want.plain_first, want.plain_second, want.status,
                   out_data.plain_first, out_data.plain_second, out_data.status);
        end
        case (want.status)
          STATUS_SAME: same_seen++;
          STATUS_MISSING: missing_seen++;
          default: ok_seen++;
        endcase
      end
    end
  end

  initial begin
    int gaps[3];
    gaps = '{34, 73, 0};
    for (int k = 0; k < 25; k++) gen_cells[k] = DEFAULT_SQUARE[5*k +: 5];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default square
    send_pair(4, 0);     // same row, left wrap
    send_pair(4, 20);    // same column, up wrap
    send_pair(23, 1);    // rectangle
    send_pair(25, 0);
    send_pair(0, 25);
    send_pair(3, 3);     // identical
    send_pair(0, 0);
    send_pair(9, 8);     // J folds onto I
    send_pair(9, 19);
    send_pair(26, 0);    // code not in square
    send_pair(0, 31);
    send_pair(31, 31);   // identical wins over missing
    send_pair(30, 9);
    wait_drained();

    load_square(SQ_ZERO);
    send_pair(0, 1);
    send_pair(1, 0);
    send_pair(0, 0);
    send_pair(31, 0);
    load_square(SQ_ONES);
    send_pair(31, 30);
    send_pair(30, 31);
    send_pair(31, 31);
    send_pair(0, 31);

    for (int m = 0; m < 3; m++) begin
      for (int s = 0; s < 3; s++) begin
        int r;
        r = $urandom_range(9);
        if (m == 2 && s == 0) load_square(SQ_DEFAULT);
        else if (r < 5) load_square(SQ_KEY);
        else if (r < 7) load_square(SQ_CODES);
        else if (r < 8) load_square(SQ_REPEATS);
        else load_square(SQ_RAW);
        send_gap_pct = gaps[m];
        repeat (45) pending_digraphs = {pending_digraphs, make_digraph()};
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_plain.size() != 0) begin
      err_count++;
      $display("%0t %0d expected transactions never arrived", $time, expected_plain.size());
    end
    $display("summary: %0d key squares, decrypted %0d, identical %0d, missing letter %0d",
             squares_loaded, ok_seen, same_seen, missing_seen);
    if (err_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/pfd_pkg.sv
rtl/core/pfd_locate.sv
rtl/core/pfd_select.sv
rtl/core/playfair_pair_decrypt_top.sv
tb/tb_playfair_pair_decrypt_top.sv
